[design/otp_pkg.sv]
package otp_pkg;

  // byte codes seen by the parser
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SP    = 8'd32;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_F     = 8'h66;

  // line parser modes
  typedef enum logic [5:0] {
    M_START   = 6'b000001,
    M_AFTER_V = 6'b000010,
    M_AFTER_F = 6'b000100,
    M_VERTEX  = 6'b001000,
    M_FACE    = 6'b010000,
    M_SKIP    = 6'b100000
  } mode_t;

  // back end sequencer
  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_DIV  = 5'b00010,
    B_PAD  = 5'b00100,
    B_GATH = 5'b01000,
    B_EMIT = 5'b10000
  } bstate_t;

  // control part of one queued work item
  typedef struct packed {
    logic       has_coord;
    logic       neg;
    logic [2:0] fpos;
    logic [1:0] slot;
    logic       do_end;
    logic [1:0] pad_from;
    logic       is_tri;
    logic       bad;
  } ent_ctl_t;

  localparam int CTL_W = $bits(ent_ctl_t);

  // powers of ten for the kept fraction digits
  function automatic logic [31:0] pow10(input logic [2:0] k);
    logic [31:0] p;
    case (k)
      3'd0: p = 32'd1;
      3'd1: p = 32'd10;
      3'd2: p = 32'd100;
      3'd3: p = 32'd1000;
      3'd4: p = 32'd10000;
      3'd5: p = 32'd100000;
      3'd6: p = 32'd1000000;
      default: p = 32'd10000000;
    endcase
    return p;
  endfunction

endpackage

[design/otp_ram.sv]
module otp_ram #(
  parameter int W = 32,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/otp_fifo.sv]
module otp_fifo #(
  parameter int W = 8,
  parameter int D = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);

  localparam int PW = $clog2(D);

  logic [W-1:0]  ent_r [D];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign full  = (cnt_r == (PW+1)'(D));
  assign empty = (cnt_r == '0);
  assign rdata = ent_r[rp_r];

  // payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(D-1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(D-1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[design/otp_front.sv]
module otp_front #(
  parameter int MAX_VERTICES = 4096,
  parameter int FRAC_DIGITS  = 6,
  parameter int FRAC_BITS    = 16
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       take,
  input  logic [7:0]                                 ch,
  input  logic                                       last,
  output logic                                       push,
  output otp_pkg::ent_ctl_t                          ctl,
  output logic [30-FRAC_BITS:0]                      ival,
  output logic [$clog2(10**FRAC_DIGITS)-1:0]         fval,
  output logic [$clog2(3*MAX_VERTICES+1)-1:0]        base,
  output logic [$clog2(MAX_VERTICES+2)-1:0]          idx0,
  output logic [$clog2(MAX_VERTICES+2)-1:0]          idx1,
  output logic [$clog2(MAX_VERTICES+2)-1:0]          idx2
);
  import otp_pkg::*;

  localparam int IB    = 31 - FRAC_BITS;
  localparam int FW    = $clog2(10**FRAC_DIGITS);
  localparam int CW    = $clog2(3*MAX_VERTICES+1);
  localparam int VW    = $clog2(MAX_VERTICES+1);
  localparam int IW    = $clog2(MAX_VERTICES+2);
  localparam logic [IB+3:0] INT_SAT = (IB+4)'((2**IB) - 1);
  localparam logic [IW+3:0] IDX_SAT = (IW+4)'(MAX_VERTICES + 1);

  mode_t          mode_r, mode_nxt;
  logic           neg_r, neg_nxt;
  logic [IB-1:0]  iacc_r, iacc_nxt;
  logic [FW-1:0]  facc_r, facc_nxt;
  logic [2:0]     fpos_r, fpos_nxt;
  logic           dig_r, dig_nxt, frc_r, frc_nxt, slh_r, slh_nxt;
  logic [IW-1:0]  xacc_r, xacc_nxt;
  logic [IW-1:0]  pc0_r, pc0_nxt, pc1_r, pc1_nxt;
  logic [1:0]     ccnt_r, ccnt_nxt;
  logic [1:0]     lcn_r, lcn_nxt;
  logic [CW-1:0]  ccount_r, ccount_nxt;
  logic [VW-1:0]  vcnt_r, vcnt_nxt;

  // byte classification
  logic       is_nl, is_sep, is_digit, do_end, full;
  logic [3:0] dval;

  assign is_nl    = (ch == CH_NL);
  assign is_sep   = (ch == CH_SP) || (ch == CH_TAB) || (ch == CH_CR) ||
                    (ch == CH_VT) || (ch == CH_FF);
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign dval     = ch[3:0];
  assign do_end   = is_nl || last;
  assign full     = (vcnt_r == VW'(MAX_VERTICES));

  // per byte parse step
  always_comb begin
    logic          close_req, face_req, slash_push, push_go;
    logic [IW-1:0] push_val, tri_c;
    logic [IB+3:0] it;
    logic [FW+3:0] ft;
    logic [IW+3:0] xt;
    close_req  = 1'b0;
    face_req   = 1'b0;
    slash_push = 1'b0;
    push_go    = 1'b0;
    push_val   = '0;
    tri_c      = '0;
    it = (IB+4)'(iacc_r) * (IB+4)'(10) + (IB+4)'(dval);
    ft = (FW+4)'(facc_r) * (FW+4)'(10) + (FW+4)'(dval);
    xt = (IW+4)'(xacc_r) * (IW+4)'(10) + (IW+4)'(dval);

    mode_nxt   = mode_r;
    neg_nxt    = neg_r;
    iacc_nxt   = iacc_r;
    facc_nxt   = facc_r;
    fpos_nxt   = fpos_r;
    dig_nxt    = dig_r;
    frc_nxt    = frc_r;
    slh_nxt    = slh_r;
    xacc_nxt   = xacc_r;
    pc0_nxt    = pc0_r;
    pc1_nxt    = pc1_r;
    ccnt_nxt   = ccnt_r;
    lcn_nxt    = lcn_r;
    ccount_nxt = ccount_r;
    vcnt_nxt   = vcnt_r;

    push = 1'b0;
    ctl  = '0;
    ival = iacc_r;
    fval = facc_r;
    base = ccount_r;
    idx0 = pc0_r;
    idx1 = pc1_r;
    idx2 = '0;

    // character within the line
    if (!is_nl) begin
      case (mode_r)
        M_START: begin
          mode_nxt = (ch == CH_V) ? M_AFTER_V : (ch == CH_F) ? M_AFTER_F : M_SKIP;
        end
        M_AFTER_V: begin
          mode_nxt = (ch == CH_SP || ch == CH_TAB) ? M_VERTEX : M_SKIP;
        end
        M_AFTER_F: begin
          mode_nxt = (ch == CH_SP || ch == CH_TAB) ? M_FACE : M_SKIP;
        end
        M_VERTEX: begin
          if (ch == CH_HASH) begin
            close_req = 1'b1;
            mode_nxt  = M_SKIP;
          end else if (is_sep) begin
            close_req = 1'b1;
          end else if (ch == CH_MINUS) begin
            if (!dig_r && !frc_r && !slh_r) neg_nxt = 1'b1;
          end else if (ch == CH_DOT) begin
            frc_nxt = 1'b1;
          end else if (is_digit) begin
            dig_nxt = 1'b1;
            if (frc_r) begin
              if (fpos_r < 3'(FRAC_DIGITS)) begin
                facc_nxt = FW'(ft);
                fpos_nxt = fpos_r + 1'b1;
              end
            end else begin
              iacc_nxt = ((IB+4)'(iacc_r) > INT_SAT || it > INT_SAT) ?
                         IB'(INT_SAT) : IB'(it);
            end
          end
        end
        M_FACE: begin
          if (ch == CH_HASH) begin
            face_req = 1'b1;
            mode_nxt = M_SKIP;
          end else if (is_sep) begin
            face_req = 1'b1;
          end else if (ch == CH_SLASH) begin
            if (!slh_r) slash_push = 1'b1;
          end else if (is_digit && !slh_r) begin
            dig_nxt  = 1'b1;
            xacc_nxt = ((IW+4)'(xacc_r) > IDX_SAT || xt > IDX_SAT) ?
                       IW'(IDX_SAT) : IW'(xt);
          end
        end
        default: mode_nxt = M_SKIP;
      endcase
    end

    // line end closes whatever number is open
    if (do_end && mode_nxt == M_VERTEX) close_req = 1'b1;
    if (do_end && mode_nxt == M_FACE)   face_req  = 1'b1;

    // index push from a slash or a separator
    if (slash_push) begin
      push_go  = dig_nxt;
      push_val = xacc_nxt;
      dig_nxt  = 1'b0;
      xacc_nxt = '0;
      slh_nxt  = 1'b1;
    end else if (face_req) begin
      push_go  = dig_nxt && !slh_nxt;
      push_val = xacc_nxt;
      dig_nxt  = 1'b0;
      xacc_nxt = '0;
      slh_nxt  = 1'b0;
    end
    if (push_go) begin
      if (ccnt_r == 2'd2) begin
        tri_c      = push_val;
        ctl.is_tri = 1'b1;
        ctl.bad    = (pc0_r == '0) || (pc0_r > IW'(vcnt_r)) ||
                     (pc1_r == '0) || (pc1_r > IW'(vcnt_r)) ||
                     (tri_c == '0) || (tri_c > IW'(vcnt_r));
        idx2       = tri_c;
        ccnt_nxt   = 2'd0;
      end else begin
        if (ccnt_r == 2'd0) pc0_nxt = push_val;
        else                pc1_nxt = push_val;
        ccnt_nxt = ccnt_r + 1'b1;
      end
    end

    // coordinate close
    if (close_req) begin
      if (dig_nxt && lcn_r != 2'd3) begin
        ctl.has_coord = !full;
        ctl.neg       = neg_nxt;
        ctl.fpos      = fpos_nxt;
        ctl.slot      = lcn_r;
        ival          = iacc_nxt;
        fval          = facc_nxt;
        lcn_nxt       = lcn_r + 1'b1;
      end
      neg_nxt  = 1'b0;
      iacc_nxt = '0;
      facc_nxt = '0;
      fpos_nxt = '0;
      dig_nxt  = 1'b0;
      frc_nxt  = 1'b0;
    end

    // line end commits the vertex
    if (do_end) begin
      if (lcn_nxt != 2'd0 && !full) begin
        ctl.do_end   = 1'b1;
        ctl.pad_from = lcn_nxt;
        ccount_nxt   = ccount_r + CW'(3);
        vcnt_nxt     = vcnt_r + 1'b1;
      end
      lcn_nxt  = '0;
      ccnt_nxt = '0;
      neg_nxt  = 1'b0;
      iacc_nxt = '0;
      facc_nxt = '0;
      fpos_nxt = '0;
      dig_nxt  = 1'b0;
      frc_nxt  = 1'b0;
      slh_nxt  = 1'b0;
      xacc_nxt = '0;
      mode_nxt = M_START;
    end

    push = take && (ctl.has_coord || ctl.do_end || ctl.is_tri);
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_START;
      neg_r    <= 1'b0;
      iacc_r   <= '0;
      facc_r   <= '0;
      fpos_r   <= '0;
      dig_r    <= 1'b0;
      frc_r    <= 1'b0;
      slh_r    <= 1'b0;
      xacc_r   <= '0;
      pc0_r    <= '0;
      pc1_r    <= '0;
      ccnt_r   <= '0;
      lcn_r    <= '0;
      ccount_r <= '0;
      vcnt_r   <= '0;
    end else if (take) begin
      mode_r   <= mode_nxt;
      neg_r    <= neg_nxt;
      iacc_r   <= iacc_nxt;
      facc_r   <= facc_nxt;
      fpos_r   <= fpos_nxt;
      dig_r    <= dig_nxt;
      frc_r    <= frc_nxt;
      slh_r    <= slh_nxt;
      xacc_r   <= xacc_nxt;
      pc0_r    <= pc0_nxt;
      pc1_r    <= pc1_nxt;
      ccnt_r   <= ccnt_nxt;
      lcn_r    <= lcn_nxt;
      ccount_r <= ccount_nxt;
      vcnt_r   <= vcnt_nxt;
    end
  end

endmodule

[design/otp_back.sv]
module otp_back #(
  parameter int MAX_VERTICES = 4096,
  parameter int FRAC_DIGITS  = 6,
  parameter int FRAC_BITS    = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_empty,
  output logic                                q_pop,
  input  otp_pkg::ent_ctl_t                   ctl,
  input  logic [30-FRAC_BITS:0]               ival,
  input  logic [$clog2(10**FRAC_DIGITS)-1:0]  fval,
  input  logic [$clog2(3*MAX_VERTICES+1)-1:0] base,
  input  logic [$clog2(MAX_VERTICES+2)-1:0]   idx0,
  input  logic [$clog2(MAX_VERTICES+2)-1:0]   idx1,
  input  logic [$clog2(MAX_VERTICES+2)-1:0]   idx2,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [31:0]                  out_a_x,
  output logic signed [31:0]                  out_a_y,
  output logic signed [31:0]                  out_a_z,
  output logic signed [31:0]                  out_b_x,
  output logic signed [31:0]                  out_b_y,
  output logic signed [31:0]                  out_b_z,
  output logic signed [31:0]                  out_c_x,
  output logic signed [31:0]                  out_c_y,
  output logic signed [31:0]                  out_c_z,
  output logic                                out_status
);
  import otp_pkg::*;

  localparam int DEPTH = 3 * MAX_VERTICES;
  localparam int AW    = $clog2(DEPTH);
  localparam int IB    = 31 - FRAC_BITS;
  localparam int FW    = $clog2(10**FRAC_DIGITS);
  localparam int PW    = $clog2(10**FRAC_DIGITS + 1);
  localparam int CW    = $clog2(3*MAX_VERTICES+1);
  localparam int IW    = $clog2(MAX_VERTICES+2);

  // fraction scaled to FRAC_DIGITS digits, divided by 10^FRAC_DIGITS as a left
  // shift by FRAC_BITS - FRAC_DIGITS and a multiply by the reciprocal of 5^FRAC_DIGITS
  localparam int     D5    = 5**FRAC_DIGITS;
  localparam int     LW    = $clog2(D5);
  localparam longint XMAX  = longint'(10**FRAC_DIGITS - 1) *
                             longint'(2**(FRAC_BITS - FRAC_DIGITS)) + longint'(D5 / 2);
  localparam int     XW    = $clog2(XMAX + 1);
  localparam int     SH    = XW + LW;
  localparam longint MR    = ((longint'(1) << SH) + longint'(D5) - 1) / longint'(D5);
  localparam int     MW    = $clog2(MR + 1);
  localparam logic [MW-1:0] MRECIP = MW'(MR);
  localparam logic [XW-1:0] HALF5  = XW'(D5 / 2);

  bstate_t st_r, st_nxt;

  logic                 neg_r, do_end_r, bad_r;
  logic [IB-1:0]        ival_r;
  logic [FW-1:0]        fr_r;
  logic [PW-1:0]        sc_r;
  logic [XW-1:0]        x_r;
  logic [XW+MW-1:0]     prod_r;
  logic [1:0]           cnt_r;
  logic [CW-1:0]        base_r;
  logic [1:0]           slot_r, padf_r;
  logic [AW-1:0]        b0_r, b1_r, b2_r;
  logic [3:0]           iss_r, cap_i_r;
  logic [1:0]           cor_r, cmp_r;
  logic                 cap_v_r;
  logic [31:0]          g_r [9];
  logic                 ov_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;
  logic          emit_go;

  otp_ram #(.W(32), .D(DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // corner base address: three words per vertex
  function automatic logic [AW-1:0] corner_base(input logic [IW-1:0] idx);
    logic [AW-1:0] m;
    m = AW'(idx - 1'b1);
    return AW'({m, 1'b0}) + m;
  endfunction

  // rounded fraction and the signed, saturated coordinate
  logic [FRAC_BITS:0]   qfin;
  logic [31:0]          mag, cval;

  assign qfin   = (FRAC_BITS+1)'(prod_r >> SH);
  assign mag    = 32'({ival_r, FRAC_BITS'(0)}) + 32'(qfin);

  always_comb begin
    logic [31:0] m;
    m    = mag[31] ? 32'h7fff_ffff : mag;
    cval = neg_r ? (32'd0 - m) : m;
  end

  // gather read address
  always_comb begin
    logic [AW-1:0] b;
    case (cor_r)
      2'd0:    b = b0_r;
      2'd1:    b = b1_r;
      default: b = b2_r;
    endcase
    raddr = b + AW'(cmp_r);
  end

  assign q_pop   = (st_r == B_IDLE) && !q_empty;
  assign emit_go = (st_r == B_EMIT) && (!ov_r || !out_stall);

  // sequencer and store writes
  always_comb begin
    st_nxt = st_r;
    we     = 1'b0;
    waddr  = AW'(base_r) + AW'(slot_r);
    wdata  = '0;
    case (st_r)
      B_IDLE: begin
        if (!q_empty) begin
          if (ctl.has_coord)   st_nxt = B_DIV;
          else if (ctl.do_end) st_nxt = B_PAD;
          else if (ctl.is_tri) st_nxt = ctl.bad ? B_EMIT : B_GATH;
        end
      end
      B_DIV: begin
        if (cnt_r == 2'd2) begin
          we     = 1'b1;
          wdata  = cval;
          st_nxt = do_end_r ? B_PAD : B_IDLE;
        end
      end
      B_PAD: begin
        if (slot_r == 2'd3) begin
          st_nxt = B_IDLE;
        end else begin
          we = 1'b1;
          if (slot_r == 2'd2) st_nxt = B_IDLE;
        end
      end
      B_GATH: begin
        if (cap_v_r && cap_i_r == 4'd8) st_nxt = B_EMIT;
      end
      B_EMIT: begin
        if (emit_go) st_nxt = B_IDLE;
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (emit_go)                ov_r <= 1'b1;
      else if (ov_r && !out_stall) ov_r <= 1'b0;
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    cap_v_r <= 1'b0;
    case (st_r)
      B_IDLE: begin
        neg_r    <= ctl.neg;
        do_end_r <= ctl.do_end;
        bad_r    <= ctl.bad;
        ival_r   <= ival;
        fr_r     <= fval;
        sc_r     <= PW'(pow10(3'(FRAC_DIGITS) - ctl.fpos));
        cnt_r    <= '0;
        base_r   <= base;
        slot_r   <= ctl.has_coord ? ctl.slot : ctl.pad_from;
        padf_r   <= ctl.pad_from;
        b0_r     <= corner_base(idx0);
        b1_r     <= corner_base(idx1);
        b2_r     <= corner_base(idx2);
        iss_r    <= '0;
        cor_r    <= '0;
        cmp_r    <= '0;
      end
      B_DIV: begin
        if (cnt_r == 2'd0) begin
          // scale the kept digits up to FRAC_DIGITS and add the rounding half
          x_r   <= (XW'(FW'((FW+PW)'(fr_r) * (FW+PW)'(sc_r))) <<
                    (FRAC_BITS - FRAC_DIGITS)) + HALF5;
          cnt_r <= cnt_r + 1'b1;
        end else if (cnt_r == 2'd1) begin
          prod_r <= (XW+MW)'(x_r) * (XW+MW)'(MRECIP);
          cnt_r  <= cnt_r + 1'b1;
        end else begin
          slot_r <= padf_r;
        end
      end
      B_PAD: begin
        slot_r <= slot_r + 1'b1;
      end
      B_GATH: begin
        if (iss_r != 4'd9) begin
          cap_v_r <= 1'b1;
          cap_i_r <= iss_r;
          iss_r   <= iss_r + 1'b1;
          if (cmp_r == 2'd2) begin
            cmp_r <= '0;
            cor_r <= cor_r + 1'b1;
          end else begin
            cmp_r <= cmp_r + 1'b1;
          end
        end
        if (cap_v_r) g_r[cap_i_r] <= rdata;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_a_x    <= bad_r ? '0 : g_r[0];
      out_a_y    <= bad_r ? '0 : g_r[1];
      out_a_z    <= bad_r ? '0 : g_r[2];
      out_b_x    <= bad_r ? '0 : g_r[3];
      out_b_y    <= bad_r ? '0 : g_r[4];
      out_b_z    <= bad_r ? '0 : g_r[5];
      out_c_x    <= bad_r ? '0 : g_r[6];
      out_c_y    <= bad_r ? '0 : g_r[7];
      out_c_z    <= bad_r ? '0 : g_r[8];
      out_status <= bad_r;
    end
  end

  assign out_valid = ov_r;

endmodule

[design/obj_text_triangle_parser_core.sv]
// channel  | handshake            | payload
// in       | in_valid / in_stall  | in_ch[7:0], in_last
// out      | out_valid / out_stall| out_{a,b,c}_{x,y,z}[31:0] signed Q.FRAC_BITS, out_status
//
// the parser takes one byte per cycle while its 4-entry queue has room
// a closed coordinate passes through the back end as pop, digit scaling, reciprocal multiply, store
// a vertex line end writes zeros into the slots that no coordinate filled
// a triangle passes through pop, nine store reads with their captures, result load
// a flagged triangle skips the reads and goes from pop straight to result load
// synchronous active-low reset clears parser and sequencer; the store is not cleared
// out_stall holds the result register; the back end waits only when a new triangle is ready
module obj_text_triangle_parser_core #(
  parameter int MAX_VERTICES = 4096,
  parameter int FRAC_DIGITS  = 6,
  parameter int FRAC_BITS    = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_ch,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_a_x,
  output logic signed [31:0] out_a_y,
  output logic signed [31:0] out_a_z,
  output logic signed [31:0] out_b_x,
  output logic signed [31:0] out_b_y,
  output logic signed [31:0] out_b_z,
  output logic signed [31:0] out_c_x,
  output logic signed [31:0] out_c_y,
  output logic signed [31:0] out_c_z,
  output logic               out_status
);
  import otp_pkg::*;

  localparam int IB = 31 - FRAC_BITS;
  localparam int FW = $clog2(10**FRAC_DIGITS);
  localparam int CW = $clog2(3*MAX_VERTICES+1);
  localparam int IW = $clog2(MAX_VERTICES+2);
  localparam int QW = CTL_W + IB + FW + CW + 3*IW;

  ent_ctl_t        f_ctl, b_ctl;
  logic [IB-1:0]   f_ival, b_ival;
  logic [FW-1:0]   f_fval, b_fval;
  logic [CW-1:0]   f_base, b_base;
  logic [IW-1:0]   f_i0, f_i1, f_i2, b_i0, b_i1, b_i2;
  logic            f_push, q_pop, q_full, q_empty, take;
  logic [QW-1:0]   q_wdata, q_rdata;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  otp_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .FRAC_DIGITS  (FRAC_DIGITS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .ch    (in_ch),
    .last  (in_last),
    .push  (f_push),
    .ctl   (f_ctl),
    .ival  (f_ival),
    .fval  (f_fval),
    .base  (f_base),
    .idx0  (f_i0),
    .idx1  (f_i1),
    .idx2  (f_i2)
  );

  // work queue between parser and back end
  assign q_wdata = {f_ctl, f_ival, f_fval, f_base, f_i0, f_i1, f_i2};
  assign {b_ctl, b_ival, b_fval, b_base, b_i0, b_i1, b_i2} = q_rdata;

  otp_fifo #(.W(QW), .D(4)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  otp_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .FRAC_DIGITS  (FRAC_DIGITS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .ctl        (b_ctl),
    .ival       (b_ival),
    .fval       (b_fval),
    .base       (b_base),
    .idx0       (b_i0),
    .idx1       (b_i1),
    .idx2       (b_i2),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_a_x    (out_a_x),
    .out_a_y    (out_a_y),
    .out_a_z    (out_a_z),
    .out_b_x    (out_b_x),
    .out_b_y    (out_b_y),
    .out_b_z    (out_b_z),
    .out_c_x    (out_c_x),
    .out_c_y    (out_c_y),
    .out_c_z    (out_c_z),
    .out_status (out_status)
  );

  // back end never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("pop from empty queue");

  // parser never pushes into a full queue
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    f_push |-> !q_full) else $error("push into full queue");

  // a flagged triangle carries zero coordinates
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_a_x == 0 && out_a_y == 0 && out_a_z == 0 &&
      out_b_x == 0 && out_b_y == 0 && out_b_z == 0 &&
      out_c_x == 0 && out_c_y == 0 && out_c_z == 0))
    else $error("flagged triangle with nonzero coordinates");

endmodule

[sim/tb_obj_text_triangle_parser_core.sv]
`timescale 1ns / 1ps

module tb_obj_text_triangle_parser_core;
  import otp_pkg::*;

  localparam int MAXV = 4096;
  localparam int FDIG = 6;
  localparam int FBITS = 16;
  localparam int DEPTH = 3 * MAXV;
  localparam logic [31:0] INT_LIMIT = (32'd1 << (31 - FBITS)) - 32'd1;
  localparam logic [31:0] IDX_LIMIT = MAXV + 1;
  localparam int CYCLE_LIMIT = 1500000;

  // number flags of the parser
  localparam logic [2:0] NUM_DIGITS = 3'd1;
  localparam logic [2:0] NUM_FRAC = 3'd2;
  localparam logic [2:0] NUM_SLASH = 3'd4;

  typedef struct {
    logic [31:0] crd[9];
    logic        bad;
  } tri_t;

  // scoreboard: parser mirror plus queue of expected triangles
  class tri_scoreboard;
    logic [31:0] coords[DEPTH];
    int unsigned ncoords;
    mode_t       mode;
    logic        neg;
    logic [31:0] ipart, fpart, fpos, idx;
    logic [2:0]  nflags;
    logic [31:0] corner[2];
    int unsigned ncorner;
    logic [31:0] lcoord[3];
    int unsigned nlcoord;
    tri_t        pending_tris[$];
    int unsigned errors, n_tris, n_bad;

    function void clear_num();
      neg = 0; ipart = 0; fpart = 0; fpos = 0; nflags = 0; idx = 0;
    endfunction

    function void reset_state();
      ncoords = 0; mode = M_START; ncorner = 0; nlcoord = 0;
      corner[0] = 0; corner[1] = 0;
      lcoord[0] = 0; lcoord[1] = 0; lcoord[2] = 0;
      clear_num();
    endfunction

    // fixed point conversion of the gathered digits
    function void close_coord();
      logic [63:0] mag, p;
      logic [31:0] m;
      if (nflags & NUM_DIGITS) begin
        mag = {32'd0, ipart} << FBITS;
        if (fpos > 0) begin
          p = 1;
          for (int k = 0; k < fpos; k++) p = p * 10;
          mag = mag + ((({32'd0, fpart} << FBITS) + p / 2) / p);
        end
        if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
        if (nlcoord < 3) begin
          m = mag[31:0];
          lcoord[nlcoord] = neg ? -m : m;
          nlcoord++;
        end
      end
      clear_num();
    endfunction

    function void make_tri(logic [31:0] last_idx);
      tri_t t;
      logic [31:0] ids[3];
      int unsigned nv;
      nv = ncoords / 3;
      ids[0] = corner[0]; ids[1] = corner[1]; ids[2] = last_idx;
      t.bad = 0;
      for (int k = 0; k < 3; k++) if (ids[k] == 0 || ids[k] > nv) t.bad = 1;
      for (int k = 0; k < 3; k++)
        for (int j = 0; j < 3; j++)
          t.crd[k * 3 + j] = t.bad ? 32'd0 : coords[((ids[k] - 1) * 3 + j) % DEPTH];
      pending_tris.push_back(t);
    endfunction

    function void push_idx();
      if (!(nflags & NUM_DIGITS)) return;
      if (ncorner >= 2) begin
        ncorner = 0;
        make_tri(idx);
      end else begin
        corner[ncorner] = idx;
        ncorner++;
      end
    endfunction

    function void face_sep();
      if (!(nflags & NUM_SLASH)) push_idx();
      clear_num();
    endfunction

    function void end_line();
      if (mode == M_VERTEX) close_coord();
      if (mode == M_FACE) face_sep();
      if (nlcoord > 0 && ncoords + 3 <= DEPTH) begin
        for (int j = 0; j < 3; j++) coords[ncoords + j] = (j < nlcoord) ? lcoord[j] : 32'd0;
        ncoords += 3;
      end
      nlcoord = 0;
      lcoord[0] = 0; lcoord[1] = 0; lcoord[2] = 0;
      ncorner = 0;
      clear_num();
      mode = M_START;
    endfunction

    // note one accepted byte; a triangle pushed by it is expected
    function void note_byte(logic [7:0] c, logic lst);
      logic is_sp, is_dig;
      logic [31:0] v;
      int unsigned before_n;
      before_n = pending_tris.size();
      is_sp = c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_VT || c == CH_FF;
      is_dig = c >= CH_ZERO && c <= CH_NINE;
      if (c == CH_NL) begin
        end_line();
        return;
      end
      case (mode)
        M_START: mode = (c == CH_V) ? M_AFTER_V : (c == CH_F) ? M_AFTER_F : M_SKIP;
        M_AFTER_V: mode = (c == CH_SP || c == CH_TAB) ? M_VERTEX : M_SKIP;
        M_AFTER_F: mode = (c == CH_SP || c == CH_TAB) ? M_FACE : M_SKIP;
        M_VERTEX: begin
          if (c == CH_HASH) begin
            close_coord(); mode = M_SKIP;
          end else if (is_sp) close_coord();
          else if (c == CH_MINUS) begin
            if (nflags == 0) neg = 1;
          end else if (c == CH_DOT) nflags |= NUM_FRAC;
          else if (is_dig) begin
            nflags |= NUM_DIGITS;
            if (nflags & NUM_FRAC) begin
              if (fpos < FDIG) begin
                fpart = fpart * 10 + (c - CH_ZERO);
                fpos++;
              end
            end else begin
              v = ipart * 10 + (c - CH_ZERO);
              ipart = (ipart > INT_LIMIT || v > INT_LIMIT) ? INT_LIMIT : v;
            end
          end
        end
        M_FACE: begin
          if (c == CH_HASH) begin
            face_sep(); mode = M_SKIP;
          end else if (is_sp) face_sep();
          else if (c == CH_SLASH) begin
            if (!(nflags & NUM_SLASH)) begin
              push_idx();
              clear_num();
              nflags = NUM_SLASH;
            end
          end else if (is_dig && !(nflags & NUM_SLASH)) begin
            v = idx * 10 + (c - CH_ZERO);
            nflags |= NUM_DIGITS;
            idx = (idx > IDX_LIMIT || v > IDX_LIMIT) ? IDX_LIMIT : v;
          end
        end
        default: mode = M_SKIP;
      endcase
      if (lst) begin
        // a triangle closed by the final flush is dropped if this byte already made one
        end_line();
        if (pending_tris.size() > before_n + 1) void'(pending_tris.pop_back());
      end
    endfunction

    task check_tri(tri_t got);
      tri_t exp_t;
      if (pending_tris.size() == 0) begin
        report_err("triangle with none expected");
        return;
      end
      exp_t = pending_tris.pop_front();
      n_tris++;
      if (exp_t.bad) n_bad++;
      if (got.bad !== exp_t.bad)
        report_err($sformatf("status got %0b exp %0b", got.bad, exp_t.bad));
      for (int k = 0; k < 9; k++)
        if (got.crd[k] !== exp_t.crd[k])
          report_err($sformatf("coord %0d got %h exp %h", k, got.crd[k], exp_t.crd[k]));
    endtask

    task report_err(string msg);
      errors++;
      if (errors <= 40) $display("mismatch at %0t: %s", $realtime, msg);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic [7:0] in_ch = 0;
  logic in_last = 0;
  logic out_stall = 0;
  logic in_stall, out_valid, out_status;
  logic signed [31:0] out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z;
  logic signed [31:0] out_c_x, out_c_y, out_c_z;

  tri_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned n_bytes = 0;
  int unsigned vert_lines = 0;
  logic stall_mode = 0;

  obj_text_triangle_parser_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_ch(in_ch), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_a_x(out_a_x), .out_a_y(out_a_y), .out_a_z(out_a_z),
    .out_b_x(out_b_x), .out_b_y(out_b_y), .out_b_z(out_b_z),
    .out_c_x(out_c_x), .out_c_y(out_c_y), .out_c_z(out_c_z),
    .out_status(out_status)
  );

  always #5 clk = ~clk;

  // result monitor and receiver stall pattern
  always @(posedge clk) begin
    tri_t got;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      got.crd[0] = out_a_x; got.crd[1] = out_a_y; got.crd[2] = out_a_z;
      got.crd[3] = out_b_x; got.crd[4] = out_b_y; got.crd[5] = out_b_z;
      got.crd[6] = out_c_x; got.crd[7] = out_c_y; got.crd[8] = out_c_z;
      got.bad = out_status;
      sb.check_tri(got);
    end
    if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
    out_stall <= stall_mode ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 9) == 0);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL obj_text_triangle_parser_core");
      $finish;
    end
  end

  // send one byte, idling between bursts
  task automatic send_byte(input logic [7:0] c, input logic lst = 0);
    if ($urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1;
    in_ch <= c;
    in_last <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(c, lst);
    n_bytes++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic string rand_num(input bit with_frac);
    string s;
    int nd;
    s = ($urandom_range(0, 2) == 0) ? "-" : "";
    case ($urandom_range(0, 9))
      0: s = {s, "32767"};
      1: s = {s, "99999999"};
      default: s = {s, $sformatf("%0d", $urandom_range(0, 300))};
    endcase
    if (with_frac) begin
      s = {s, "."};
      nd = $urandom_range(0, 9);
      for (int i = 0; i < nd; i++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
    end
    return s;
  endfunction

  task automatic send_vertex();
    string s;
    int n;
    s = "v";
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : 3;
    for (int i = 0; i < n; i++) s = {s, ($urandom_range(0, 3) == 0) ? "\t" : " ",
                                     rand_num($urandom_range(0, 1))};
    send_str({s, "\n"});
    vert_lines++;
  endtask

  task automatic send_face();
    string s;
    int n, nv, iv;
    nv = sb.ncoords / 3;
    s = "f";
    n = $urandom_range(0, 9) == 0 ? $urandom_range(1, 7) : 3 * $urandom_range(1, 2);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) iv = $urandom_range(0, 1) ? 0 : nv + 1;
      else iv = (nv == 0) ? 1 : $urandom_range(1, nv);
      s = {s, " ", $sformatf("%0d", iv)};
      case ($urandom_range(0, 3))
        1: s = {s, "/", $sformatf("%0d", $urandom_range(1, 9))};
        2: s = {s, "//", $sformatf("%0d", $urandom_range(1, 9))};
        3: s = {s, "/2/3"};
        default: ;
      endcase
    end
    send_str({s, "\n"});
  endtask

  initial begin
    sb.reset_state();
    sb.errors = 0; sb.n_tris = 0; sb.n_bad = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, keywords off line start, comments, empty groups, last flush
    send_str("# comment v 1 2 3\n");
    send_str("v 32767.9999995 -99999 .5\n");
    send_str("v\t-0.0000005 1.25.7 -3-4 9 8\n");
    send_str("v 7\n");
    send_str("v\n");
    send_str(" v 1 1 1\nvt 0.5 0.5\nvn 0 0 1\ns off\n");
    send_str("f 1 2 3 4\n");
    send_str("f 1/2/3 2//4  3/ # 4 5\n");
    send_str("f 0 1 2\nf 1 2 99999999\nf -1 / 2 3x\n");
    send_str("v 1 2 3 # 4\n");
    send_byte(8'hff); send_byte(8'h00); send_byte(CH_NL);
    send_str("f 1 2 ");
    send_byte("3", 1);

    // hold off until every triangle has come
    in_valid <= 0;
    while (sb.pending_tris.size() != 0) @(posedge clk);

    // random: mostly well-formed lines, some noise
    while (n_bytes < 1300) begin
      case ($urandom_range(0, 9))
        0, 1, 2: send_vertex();
        3, 4, 5, 6: send_face();
        7: send_str("# junk\n");
        8: begin
          for (int i = 0; i < $urandom_range(1, 12); i++) send_byte($urandom_range(0, 255));
        end
        default: begin
          send_face();
          if ($urandom_range(0, 3) == 0) send_byte("1", 1);
        end
      endcase
    end

    in_valid <= 0;
    in_last <= 0;
    while (sb.pending_tris.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d bytes, %0d vertex lines, %0d vertices stored",
             n_bytes, vert_lines, sb.ncoords / 3);
    $display("checked %0d triangles, %0d with bad indices", sb.n_tris, sb.n_bad);
    if (sb.errors == 0) begin
      $display("PASS obj_text_triangle_parser_core");
    end else begin
      $display("FAIL obj_text_triangle_parser_core");
    end
    $finish;
  end

endmodule
